/* design/rsc_pkg.sv */
// Shared types, constants and helpers for the radix string converter.
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int DIGIT_DEPTH = 64;
  localparam int ACC_W       = 64;
  localparam int BASE_W      = 6;
  localparam int DIV_BITS    = 8;
  localparam int JQ_DEPTH    = 2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_BASE  = 2'd1;
  localparam logic [1:0] ST_NO_DIGITS = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam logic REG_SOURCE_BASE = 1'b0;
  localparam logic REG_TARGET_BASE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  localparam logic [6:0] ASCII_ZERO = 7'h30;

  typedef struct packed {
    logic [1:0]       status;
    logic [ACC_W-1:0] value;
  } job_t;

  // Digit value 0..35 to uppercase ASCII.
  function automatic logic [6:0] digit_ascii(input logic [BASE_W-1:0] d);
    logic [6:0] code;
    if (d > 6'd9) code = {1'b0, d} + 7'd55;
    else code = {1'b0, d} + ASCII_ZERO;
    return code;
  endfunction

endpackage

/* design/rsc_front.sv */
// Character parser: skips whitespace, takes sign and hex prefix, accumulates digits.
`timescale 1ns / 1ps

module rsc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [7:0]                char_code,
  input  logic                      is_final,
  input  logic [rsc_pkg::BASE_W-1:0] source_base,
  input  logic [rsc_pkg::BASE_W-1:0] target_base,
  output logic                      job_push,
  output rsc_pkg::job_t             job_data
);

  localparam logic [2:0] PH_WS     = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_HEX    = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_STOP   = 3'd5;

  localparam int AW = rsc_pkg::ACC_W;

  logic [AW-1:0] acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic          seen_r, seen_nxt;
  logic          ovf_r, ovf_nxt;

  logic [rsc_pkg::BASE_W-1:0] base_eff;
  logic [6:0]      cval;
  logic            is_dig;
  logic            is_space;
  logic            is_pm;
  logic [AW+5:0]   prod;
  logic [AW+6:0]   sum;
  logic [AW+6:0]   limit;
  logic            over;
  logic            take_sign;
  logic            take_zero;
  logic            zero_x;
  logic            do_digit;

  always_comb begin
    base_eff = (source_base > rsc_pkg::BASE_MAX) ? rsc_pkg::BASE_MAX : source_base;
    if (char_code >= 8'h30 && char_code <= 8'h39) cval = 7'(char_code - 8'h30);
    else if (char_code >= 8'h41 && char_code <= 8'h5A) cval = 7'(char_code - 8'h37);
    else if (char_code >= 8'h61 && char_code <= 8'h7A) cval = 7'(char_code - 8'h57);
    else cval = 7'd99;
    is_dig   = cval < {1'b0, base_eff};
    is_space = (char_code == 8'h20) || (char_code >= 8'd9 && char_code <= 8'd13);
    is_pm    = (char_code == 8'h2B) || (char_code == 8'h2D);

    // acc*base + d > limit is the same test as acc > (limit - d) / base.
    prod  = acc_r * base_eff;
    sum   = {1'b0, prod} + {{(AW){1'b0}}, cval};
    limit = {7'd0, neg_r, {(AW-1){~neg_r}}};
    over  = sum > limit;

    take_sign = (phase_r == PH_WS && !is_space && !is_pm) || (phase_r == PH_SIGN);
    take_zero = take_sign && (source_base == rsc_pkg::BASE_HEX) && (char_code == 8'h30);
    zero_x    = (phase_r == PH_ZERO) && (char_code == 8'h78 || char_code == 8'h58);
    do_digit  = (take_sign && !take_zero) || (phase_r == PH_ZERO && !zero_x) ||
                (phase_r == PH_HEX) || (phase_r == PH_DIGITS);

    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;

    if (phase_r == PH_WS && !is_space && is_pm) begin
      neg_nxt   = (char_code == 8'h2D);
      phase_nxt = PH_SIGN;
    end else if (take_zero) begin
      seen_nxt  = 1'b1;
      phase_nxt = PH_ZERO;
    end else if (zero_x) begin
      phase_nxt = PH_HEX;
    end else if (do_digit) begin
      if (is_dig) begin
        seen_nxt  = 1'b1;
        phase_nxt = PH_DIGITS;
        if (!ovf_r) begin
          if (over) begin
            ovf_nxt = 1'b1;
            acc_nxt = '0;
          end else begin
            acc_nxt = sum[AW-1:0];
          end
        end
      end else begin
        phase_nxt = PH_STOP;
      end
    end else if (phase_r != PH_WS) begin
      phase_nxt = PH_STOP;
    end

    job_push = accept && is_final;
    if (!seen_nxt) job_data.status = rsc_pkg::ST_NO_DIGITS;
    else if (ovf_nxt) job_data.status = rsc_pkg::ST_OVERFLOW;
    else if (target_base < rsc_pkg::BASE_MIN || target_base > rsc_pkg::BASE_MAX)
      job_data.status = rsc_pkg::ST_BAD_BASE;
    else job_data.status = rsc_pkg::ST_OK;
    job_data.value = neg_nxt ? '0 : acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && is_final)) begin
      acc_r   <= '0;
      neg_r   <= 1'b0;
      phase_r <= PH_WS;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

/* design/rsc_job_queue.sv */
// Two-entry queue of parsed numbers between the parser and the converter.
`timescale 1ns / 1ps

module rsc_job_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rsc_pkg::job_t push_data,
  input  logic          pop,
  output logic          valid,
  output logic          full,
  output rsc_pkg::job_t pop_data
);

  localparam int PTR_W = $clog2(rsc_pkg::JQ_DEPTH);
  localparam int CNT_W = $clog2(rsc_pkg::JQ_DEPTH + 1);

  rsc_pkg::job_t    mem_r [rsc_pkg::JQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign valid    = cnt_r != '0;
  assign full     = cnt_r == CNT_W'(rsc_pkg::JQ_DEPTH);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* design/rsc_back.sv */
// Converter: repeated division by the target base, digit store, result register.
`timescale 1ns / 1ps

module rsc_back #(
  parameter int DIGIT_DEPTH = rsc_pkg::DIGIT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rsc_pkg::BASE_W-1:0] target_base,
  input  logic                       job_valid,
  input  rsc_pkg::job_t              job_data,
  output logic                       job_pop,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [6:0]                 out_digit_code,
  output logic                       out_last_digit,
  output logic [1:0]                 out_status
);

  localparam int AW     = rsc_pkg::ACC_W;
  localparam int BW     = rsc_pkg::BASE_W;
  localparam int DB     = rsc_pkg::DIV_BITS;
  localparam int STEPS  = AW / DB;
  localparam int STEP_W = $clog2(STEPS);
  localparam int ADDR_W = $clog2(DIGIT_DEPTH);
  localparam int CNT_W  = ADDR_W + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV      = 3'd1;
  localparam logic [2:0] S_RD       = 3'd2;
  localparam logic [2:0] S_SEND_DIG = 3'd3;
  localparam logic [2:0] S_SEND_ONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     work_r, work_nxt;
  logic [BW-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [6:0]        pend_code_r, pend_code_nxt;
  logic [1:0]        pend_status_r, pend_status_nxt;
  logic [BW-1:0]     rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_code_r;
  logic              out_last_r;
  logic [1:0]        out_status_r;

  logic [BW-1:0]     mem [DIGIT_DEPTH];
  logic [CNT_W-1:0]  cnt_dec;
  logic              slot_free;
  logic              load_out;
  logic              dig_done;
  logic [BW:0]       r;
  logic [DB-1:0]     qbits;
  logic [BW-1:0]     div_rem;
  logic [AW-1:0]     div_quot;

  // One radix-2 restoring step per bit, DIV_BITS bits a cycle.
  always_comb begin
    r     = {1'b0, rem_r};
    qbits = '0;
    for (int i = 0; i < DB; i++) begin
      r = {r[BW-1:0], work_r[AW-1-i]};
      if (r >= {1'b0, target_base}) begin
        r = r - {1'b0, target_base};
        qbits[DB-1-i] = 1'b1;
      end
    end
    div_rem  = r[BW-1:0];
    div_quot = {work_r[AW-DB-1:0], qbits};
  end

  assign cnt_dec   = count_r - 1'b1;
  assign slot_free = !out_valid_r || out_pop;
  assign load_out  = (state_r == S_SEND_ONE || state_r == S_SEND_DIG) && slot_free;
  assign dig_done  = (state_r == S_DIV) && (step_r == STEP_W'(STEPS - 1));
  assign job_pop   = (state_r == S_IDLE) && job_valid;

  always_comb begin
    state_nxt       = state_r;
    work_nxt        = work_r;
    rem_nxt         = rem_r;
    step_nxt        = step_r;
    count_nxt       = count_r;
    pend_code_nxt   = pend_code_r;
    pend_status_nxt = pend_status_r;
    out_valid_nxt   = load_out ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          if (job_data.status != rsc_pkg::ST_OK) begin
            pend_code_nxt   = '0;
            pend_status_nxt = job_data.status;
            state_nxt       = S_SEND_ONE;
          end else if (job_data.value == '0) begin
            pend_code_nxt   = rsc_pkg::ASCII_ZERO;
            pend_status_nxt = rsc_pkg::ST_OK;
            state_nxt       = S_SEND_ONE;
          end else begin
            work_nxt  = job_data.value;
            rem_nxt   = '0;
            step_nxt  = '0;
            count_nxt = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        work_nxt = div_quot;
        rem_nxt  = div_rem;
        step_nxt = step_r + 1'b1;
        if (dig_done) begin
          rem_nxt   = '0;
          count_nxt = count_r + 1'b1;
          if (div_quot == '0) state_nxt = S_RD;
        end
      end
      S_RD: begin
        count_nxt = cnt_dec;
        state_nxt = S_SEND_DIG;
      end
      S_SEND_DIG: begin
        if (slot_free) state_nxt = (count_r == '0) ? S_IDLE : S_RD;
      end
      S_SEND_ONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r        <= work_nxt;
    rem_r         <= rem_nxt;
    step_r        <= step_nxt;
    pend_code_r   <= pend_code_nxt;
    pend_status_r <= pend_status_nxt;
    if (load_out) begin
      if (state_r == S_SEND_DIG) begin
        out_code_r   <= rsc_pkg::digit_ascii(rd_data_r);
        out_last_r   <= count_r == '0;
        out_status_r <= rsc_pkg::ST_OK;
      end else begin
        out_code_r   <= pend_code_r;
        out_last_r   <= 1'b1;
        out_status_r <= pend_status_r;
      end
    end
  end

  // Digit store: least significant digit at the lowest address.
  always_ff @(posedge clk) begin
    if (dig_done) mem[count_r[ADDR_W-1:0]] <= div_rem;
    if (state_r == S_RD) rd_data_r <= mem[cnt_dec[ADDR_W-1:0]];
  end

  assign out_empty      = !out_valid_r;
  assign out_digit_code = out_code_r;
  assign out_last_digit = out_last_r;
  assign out_status     = out_status_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DIGIT_DEPTH))
    else $error("digit count beyond store depth");

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < target_base))
    else $error("partial remainder not below target base");

  a_error_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != rsc_pkg::ST_OK) |-> (out_code_r == '0 && out_last_r))
    else $error("error beat must carry code 0 and last flag");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (state_r != S_IDLE))
    else $error("job taken without starting work");
`endif

endmodule

/* design/radix_string_converter_top.sv */
// Top level of the radix string converter: APB registers, parser, job queue, converter.
`timescale 1ns / 1ps

// Characters enter on the input queue (push/full), one beat per character;
// in_is_final marks the last character of a number. The parser takes one
// beat per cycle while full is low; full is high only while both job queue
// slots hold parsed numbers waiting for the converter.
// Results leave on the output queue (empty/pop): uppercase digits, most
// significant first, last_digit on the final beat; an error gives one beat
// with digit code 0 and the status code.
// An error or a zero value passes from the job queue through the converter's
// pending code and status registers into the output register. Otherwise the
// divider produces every result digit in turn (eight quotient bits per
// cycle over 64 bits) into the digit store; then each digit is read from the
// store (S_RD) and loaded into the output register (S_SEND_DIG), most
// significant first.
// A stalled receiver holds the output register; the converter waits and
// the job queue absorbs up to two more numbers before full rises.
// Reset (rst_n low at a clock edge) clears the parser, the queue and the
// converter and sets both bases to 10. No clearing pass is needed.
// Registers: source_base at byte address 0, target_base at byte address 4.

module radix_string_converter_top #(
  parameter int DIGIT_DEPTH = rsc_pkg::DIGIT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  input  logic        in_is_final,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  out_digit_code,
  output logic        out_last_digit,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int BW = rsc_pkg::BASE_W;

  logic [BW-1:0]  source_base_r;
  logic [BW-1:0]  target_base_r;
  logic           cfg_write;
  logic           in_accept;
  logic           job_push;
  rsc_pkg::job_t  job_in;
  rsc_pkg::job_t  job_out;
  logic           job_valid;
  logic           job_pop;
  logic           jq_full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == rsc_pkg::REG_TARGET_BASE) ?
                     {{(32-BW){1'b0}}, target_base_r} : {{(32-BW){1'b0}}, source_base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_base_r <= rsc_pkg::BASE_RESET;
      target_base_r <= rsc_pkg::BASE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == rsc_pkg::REG_SOURCE_BASE) source_base_r <= pwdata[BW-1:0];
      else target_base_r <= pwdata[BW-1:0];
    end
  end

  assign full      = jq_full;
  assign in_accept = push && !full;

  rsc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .char_code   (in_char_code),
    .is_final    (in_is_final),
    .source_base (source_base_r),
    .target_base (target_base_r),
    .job_push    (job_push),
    .job_data    (job_in)
  );

  rsc_job_queue u_job_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .valid     (job_valid),
    .full      (jq_full),
    .pop_data  (job_out)
  );

  rsc_back #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .target_base    (target_base_r),
    .job_valid      (job_valid),
    .job_data       (job_out),
    .job_pop        (job_pop),
    .out_pop        (pop),
    .out_empty      (empty),
    .out_digit_code (out_digit_code),
    .out_last_digit (out_last_digit),
    .out_status     (out_status)
  );

endmodule

/* tb/sv/radix_string_converter_top_tb.sv */
// Self-checking testbench for the radix string converter top level.
`timescale 1ns / 1ps

module radix_string_converter_top_tb;

  localparam int         NOT_A_DIGIT   = 99;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam int         DRAIN_LIMIT   = 50000;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         PHASE_CHARS   = 10;

  typedef enum logic [2:0] {
    PARSE_WS, PARSE_SIGN, PARSE_ZERO, PARSE_HEX, PARSE_DIGITS, PARSE_STOP
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_beat_t;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
    logic [1:0] status;
  } digit_beat_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_char_code = 8'd0;
  logic        in_is_final = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [6:0]  out_digit_code;
  logic        out_last_digit;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  char_beat_t  char_queue[$];
  digit_beat_t expected_beats[$];
  bit          burst_mode = 1'b0;
  int          failures = 0;
  int          beats_checked = 0;
  int          numbers_seen = 0;
  int          error_numbers = 0;
  int          settings_used = 1;

  // Mirror of the converter: base registers and parser state.
  logic [5:0]   src_radix = rsc_pkg::BASE_RESET;
  logic [5:0]   tgt_radix = rsc_pkg::BASE_RESET;
  logic [63:0]  magnitude = 64'd0;
  logic         minus = 1'b0;
  logic         any_digit = 1'b0;
  logic         too_big = 1'b0;
  parse_phase_t phase = PARSE_WS;

  radix_string_converter_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_char_code   (in_char_code),
    .in_is_final    (in_is_final),
    .empty          (empty),
    .pop            (pop),
    .out_digit_code (out_digit_code),
    .out_last_digit (out_last_digit),
    .out_status     (out_status),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic int char_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    if (c >= "a" && c <= "z") return c - "a" + 10;
    return NOT_A_DIGIT;
  endfunction

  // Accumulates one digit of the source base; returns 0 for a non-digit.
  function automatic bit absorb_digit(logic [7:0] c);
    logic [63:0] radix;
    logic [63:0] val;
    logic [63:0] ceiling;
    radix = (src_radix > rsc_pkg::BASE_MAX) ? 64'(rsc_pkg::BASE_MAX) : 64'(src_radix);
    val = 64'(char_digit(c));
    if (val >= radix) return 1'b0;
    any_digit = 1'b1;
    if (!too_big) begin
      ceiling = minus ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (magnitude > (ceiling - val) / radix) begin
        too_big = 1'b1;
        magnitude = 64'd0;
      end else begin
        magnitude = magnitude * radix + val;
      end
    end
    return 1'b1;
  endfunction

  task automatic predict_conversion(logic [7:0] c, logic fin);
    bit          fresh;
    logic [63:0] rest;
    int          digs[$];
    logic [6:0]  code;
    fresh = 1'b0;
    case (phase)
      PARSE_WS: begin
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
        end else if (c == "+" || c == "-") begin
          minus = (c == "-");
          phase = PARSE_SIGN;
        end else begin
          fresh = 1'b1;
        end
      end
      PARSE_SIGN: fresh = 1'b1;
      PARSE_ZERO: begin
        if (c == "x" || c == "X") phase = PARSE_HEX;
        else phase = absorb_digit(c) ? PARSE_DIGITS : PARSE_STOP;
      end
      PARSE_HEX, PARSE_DIGITS: phase = absorb_digit(c) ? PARSE_DIGITS : PARSE_STOP;
      default: phase = PARSE_STOP;
    endcase
    if (fresh) begin
      // A leading zero in base 16 counts as a digit and may open a 0x prefix.
      if (src_radix == rsc_pkg::BASE_HEX && c == "0") begin
        any_digit = 1'b1;
        phase = PARSE_ZERO;
      end else begin
        phase = absorb_digit(c) ? PARSE_DIGITS : PARSE_STOP;
      end
    end
    if (!fin) return;

    numbers_seen++;
    if (!any_digit || too_big || tgt_radix < rsc_pkg::BASE_MIN ||
        tgt_radix > rsc_pkg::BASE_MAX) begin
      error_numbers++;
      expected_beats.push_back(digit_beat_t'{7'd0, 1'b1,
          !any_digit ? rsc_pkg::ST_NO_DIGITS :
          (too_big ? rsc_pkg::ST_OVERFLOW : rsc_pkg::ST_BAD_BASE)});
    end else begin
      rest = minus ? 64'd0 : magnitude;
      if (rest == 64'd0) begin
        expected_beats.push_back(digit_beat_t'{rsc_pkg::ASCII_ZERO, 1'b1, rsc_pkg::ST_OK});
      end
      while (rest != 64'd0) begin
        digs.push_front(int'(rest % 64'(tgt_radix)));
        rest = rest / 64'(tgt_radix);
      end
      for (int i = 0; i < digs.size(); i++) begin
        code = (digs[i] > 9) ? 7'(ASCII_UPPER_A + digs[i] - 10) :
                               7'(rsc_pkg::ASCII_ZERO + digs[i]);
        expected_beats.push_back(digit_beat_t'{code, i == digs.size() - 1, rsc_pkg::ST_OK});
      end
    end
    magnitude = 64'd0;
    minus = 1'b0;
    any_digit = 1'b0;
    too_big = 1'b0;
    phase = PARSE_WS;
  endtask

  // Character source: holds a beat while full; idles at random when not bursting.
  always @(posedge clk) begin : drive_chars
    char_beat_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (char_queue.size() != 0 && (burst_mode || $urandom_range(99) >= 36)) begin
        nxt = char_queue.pop_front();
        push <= 1'b1;
        in_char_code <= nxt.ch;
        in_is_final <= nxt.fin;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= burst_mode || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin : watch_beats
    digit_beat_t got;
    digit_beat_t want;
    if (rst_n) begin
      if (push && !full) predict_conversion(in_char_code, in_is_final);
      if (pop && !empty) begin
        got = digit_beat_t'{out_digit_code, out_last_digit, out_status};
        beats_checked++;
        if (expected_beats.size() == 0) begin
          note_failure($sformatf("unexpected beat code=%h last=%b status=%0d",
                                 got.code, got.last, got.status));
        end else begin
          want = expected_beats.pop_front();
          if (got !== want)
            note_failure($sformatf("beat code=%h last=%b status=%0d, expected %h %b %0d",
                                   got.code, got.last, got.status,
                                   want.code, want.last, want.status));
        end
      end
    end
  end

  task automatic write_base(logic idx, logic [5:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == rsc_pkg::REG_SOURCE_BASE) src_radix = value;
    else tgt_radix = value;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[5:0] !== value)
      note_failure($sformatf("register %0d reads %h, expected %h", idx, prdata, value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_char(logic [7:0] c, logic fin);
    char_queue.push_back(char_beat_t'{c, fin});
  endtask

  task automatic add_text(string s, bit fin_at_end);
    for (int i = 0; i < s.len(); i++) add_char(s[i], fin_at_end && i == s.len() - 1);
  endtask

  // Appends one number: mostly well-formed with random content, some noise.
  task automatic add_number();
    int          radix;
    int          pick;
    int          len;
    int          maxd;
    int          v;
    bit          trail;
    logic [7:0]  c;
    logic [63:0] top;
    radix = (src_radix < rsc_pkg::BASE_MIN) ? 2 :
            ((src_radix > rsc_pkg::BASE_MAX) ? 36 : int'(src_radix));
    pick = $urandom_range(99);
    if (pick < 15) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) add_char(8'($urandom_range(255)), i == len - 1);
      return;
    end
    if (pick < 22) begin
      case ($urandom_range(2))
        0: add_text("-", 1'b1);
        1: add_text("+-7", 1'b1);
        default: add_text(" 0x", 1'b1);
      endcase
      return;
    end
    if ($urandom_range(3) == 0) begin
      c = 8'($urandom_range(8, 13));
      if (c == 8'd8) c = " ";
      add_char(c, 1'b0);
    end
    case ($urandom_range(4))
      0: add_char("+", 1'b0);
      1: add_char("-", 1'b0);
      default: ;
    endcase
    if (src_radix == rsc_pkg::BASE_HEX && $urandom_range(2) == 0) begin
      add_char("0", 1'b0);
      add_char($urandom_range(1) ? "x" : "X", 1'b0);
    end
    if ($urandom_range(99) < 15) begin
      // Lengths around the widest value, so that some numbers overflow.
      top = 64'h7FFF_FFFF_FFFF_FFFF;
      maxd = 0;
      while (top != 64'd0) begin
        top = top / 64'(radix);
        maxd++;
      end
      len = maxd - 1 + $urandom_range(2);
    end else begin
      len = $urandom_range(1, 5);
    end
    trail = ($urandom_range(4) == 0);
    for (int i = 0; i < len; i++) begin
      v = $urandom_range(radix - 1);
      if (v < 10) c = 8'("0" + v);
      else c = 8'(($urandom_range(1) ? "A" : "a") + v - 10);
      add_char(c, !trail && i == len - 1);
    end
    if (trail) add_char(8'($urandom_range(255)), 1'b1);
  endtask

  // Waits until every queued character is taken and every expected beat has come.
  // The check runs on the falling edge, after the driver and monitor have settled.
  task automatic drain_and_settle();
    int waited;
    waited = 0;
    while ((char_queue.size() != 0 || push || expected_beats.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_beats.size() != 0) begin
      note_failure($sformatf("%0d expected beats never arrived", expected_beats.size()));
      expected_beats.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int src_tbl[7];
    int tgt_tbl[7];
    int budget;
    src_tbl = '{16, 2, 36, 63, 0, 1, 8};
    tgt_tbl = '{36, 2, 2, 63, 0, 37, 10};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset bases: blanks only, negative, zero, plain, NUL, and a stop mid-string.
    add_text(" ", 1'b1);
    add_text("\t-42", 1'b1);
    add_text("+0", 1'b1);
    add_text("907", 1'b1);
    add_char(8'h00, 1'b1);
    add_text("12a", 1'b0);
    add_char(8'hFF, 1'b1);
    drain_and_settle();

    for (int p = 0; p < 9; p++) begin
      write_base(rsc_pkg::REG_SOURCE_BASE,
                 (p < 7) ? 6'(src_tbl[p]) : 6'($urandom_range(2, 36)));
      write_base(rsc_pkg::REG_TARGET_BASE,
                 (p < 7) ? 6'(tgt_tbl[p]) : 6'($urandom_range(2, 36)));
      settings_used++;
      burst_mode = (p == 2);
      if (p == 0) begin
        // Hex prefix forms: bare prefix, negative upper-case prefix, positive value.
        add_text("0x", 1'b1);
        add_text("-0XfF", 1'b1);
        add_text("0x1f", 1'b1);
      end
      budget = char_queue.size() + PHASE_CHARS;
      while (char_queue.size() < budget) add_number();
      drain_and_settle();
    end
    burst_mode = 1'b0;

    $display("Parsed %0d numbers under %0d base settings, %0d of them ending in an error.",
             numbers_seen, settings_used, error_numbers);
    $display("Checked %0d result beats; %0d failures.", beats_checked, failures);
    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2_400_000;
    $display("simulation failed");
    $finish;
  end

endmodule
